>>> sv/mkpd_pkg.sv
// types, codes and letter table for the morse key press decoder
`default_nettype none

package mkpd_pkg;

  localparam int unsigned TIME_W  = 16;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned WLEN_W  = 6;
  localparam int unsigned BITS_W  = 5;
  localparam int unsigned COUNT_W = 3;

  localparam logic [COUNT_W-1:0] MAX_ELEMENTS = 3'd5;
  localparam logic [COUNT_W-1:0] TOO_LONG     = 3'd6;

  localparam logic [TIME_W-1:0] GAP_RESET    = 16'd50;
  localparam logic [TIME_W-1:0] DOT_RESET    = 16'd2000;
  localparam logic [TIME_W-1:0] DASH_RESET   = 16'd4000;
  localparam logic [TIME_W-1:0] LETTER_RESET = 16'd10000;

  typedef enum logic [2:0] {
    EV_DOT      = 3'd0,
    EV_DASH     = 3'd1,
    EV_LETTER   = 3'd2,
    EV_INVALID  = 3'd3,
    EV_WORD_END = 3'd4
  } event_kind_t;

  typedef enum logic [1:0] {
    REG_DEBOUNCE_GAP = 2'd0,
    REG_DOT_LIMIT    = 2'd1,
    REG_DASH_LIMIT   = 2'd2,
    REG_LETTER_LIMIT = 2'd3
  } cfg_reg_t;

  // element count and pattern (bit i set means element i is a dash) to ascii, 0 if none
  function automatic logic [CHAR_W-1:0] lookup_code(input logic [COUNT_W-1:0] count,
                                                    input logic [BITS_W-1:0] bits);
    logic [CHAR_W-1:0] ch;
    ch = '0;
    case ({count, bits})
      {3'd2, 5'd2}:  ch = 7'("A");
      {3'd4, 5'd1}:  ch = 7'("B");
      {3'd4, 5'd5}:  ch = 7'("C");
      {3'd3, 5'd1}:  ch = 7'("D");
      {3'd1, 5'd0}:  ch = 7'("E");
      {3'd4, 5'd4}:  ch = 7'("F");
      {3'd3, 5'd3}:  ch = 7'("G");
      {3'd4, 5'd0}:  ch = 7'("H");
      {3'd2, 5'd0}:  ch = 7'("I");
      {3'd4, 5'd14}: ch = 7'("J");
      {3'd3, 5'd5}:  ch = 7'("K");
      {3'd4, 5'd2}:  ch = 7'("L");
      {3'd2, 5'd3}:  ch = 7'("M");
      {3'd2, 5'd1}:  ch = 7'("N");
      {3'd3, 5'd7}:  ch = 7'("O");
      {3'd4, 5'd6}:  ch = 7'("P");
      {3'd4, 5'd11}: ch = 7'("Q");
      {3'd3, 5'd2}:  ch = 7'("R");
      {3'd3, 5'd0}:  ch = 7'("S");
      {3'd1, 5'd1}:  ch = 7'("T");
      {3'd3, 5'd4}:  ch = 7'("U");
      {3'd4, 5'd8}:  ch = 7'("V");
      {3'd3, 5'd6}:  ch = 7'("W");
      {3'd4, 5'd9}:  ch = 7'("X");
      {3'd4, 5'd13}: ch = 7'("Y");
      {3'd4, 5'd3}:  ch = 7'("Z");
      {3'd5, 5'd31}: ch = 7'("0");
      {3'd5, 5'd30}: ch = 7'("1");
      {3'd5, 5'd28}: ch = 7'("2");
      {3'd5, 5'd24}: ch = 7'("3");
      {3'd5, 5'd16}: ch = 7'("4");
      {3'd5, 5'd0}:  ch = 7'("5");
      {3'd5, 5'd1}:  ch = 7'("6");
      {3'd5, 5'd3}:  ch = 7'("7");
      {3'd5, 5'd7}:  ch = 7'("8");
      {3'd5, 5'd15}: ch = 7'("9");
      default:       ch = '0;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> sv/morse_key_press_decoder.sv
// morse key press decoder: debounce, press timing, element collection and letter decode
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata: key_level, time_ms
//  m_*       out  m_tvalid/m_tready  m_tuser: event_kind; m_tdata: char_code, press_time,
//                                    word_length
//  cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
//  one word per cycle sustained while no result waits untaken; a sample is held in the input
//  register and its result is registered into the output register, which raises m_tvalid.
//  the key state update is the loop that sets this rate.
//  synchronous reset restores the default limits and clears the key and letter state.
//  a release stalls in the input register only while the output register holds an untaken
//  result; presses and ignored samples pass through without waiting.
`default_nettype none

module morse_key_press_decoder #(
  parameter int unsigned WORD_STORE_SIZE = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [0] key_level, [16:1] time_ms, [23:17] zero
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [6:0] char_code, [22:7] press_time,
                                      // [28:23] word_length, [31:29] zero
  output logic [7:0]       m_tuser,   // [2:0] event_kind, [7:3] zero
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  import mkpd_pkg::*;

  localparam logic [WLEN_W-1:0] WORD_FULL = WLEN_W'(WORD_STORE_SIZE - 1);

  // configuration
  logic [TIME_W-1:0] debounce_gap;
  logic [TIME_W-1:0] dot_limit;
  logic [TIME_W-1:0] dash_limit;
  logic [TIME_W-1:0] letter_limit;

  // input register
  logic              in_valid;
  logic              in_level;
  logic [TIME_W-1:0] in_time;

  // decoder state
  logic               key_down, key_down_next;
  logic [TIME_W-1:0]  last_edge_time, last_edge_time_next;
  logic [TIME_W-1:0]  press_start_time, press_start_time_next;
  logic [BITS_W-1:0]  element_bits, element_bits_next;
  logic [COUNT_W-1:0] element_count, element_count_next;
  logic [WLEN_W-1:0]  letters_in_word, letters_in_word_next;

  // output register
  logic              out_valid;
  event_kind_t       out_kind;
  logic [CHAR_W-1:0] out_char;
  logic [TIME_W-1:0] out_time;
  logic [WLEN_W-1:0] out_len;

  logic              edge_ok;
  logic              has_result;
  logic              out_free;
  logic              advance;
  logic [TIME_W-1:0] since;
  logic [TIME_W-1:0] dur;
  logic              is_dash;
  logic [CHAR_W-1:0] code_char;
  event_kind_t       kind_next;
  logic [CHAR_W-1:0] char_next;
  logic [WLEN_W-1:0] len_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_gap <= GAP_RESET;
      dot_limit    <= DOT_RESET;
      dash_limit   <= DASH_RESET;
      letter_limit <= LETTER_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEBOUNCE_GAP: debounce_gap <= cfg_data;
        REG_DOT_LIMIT:    dot_limit    <= cfg_data;
        REG_DASH_LIMIT:   dash_limit   <= cfg_data;
        REG_LETTER_LIMIT: letter_limit <= cfg_data;
        default:          debounce_gap <= debounce_gap;
      endcase
    end
  end

  assign since      = in_time - last_edge_time;
  assign dur        = in_time - press_start_time;
  assign edge_ok    = (since > debounce_gap) && (in_level != key_down);
  assign has_result = edge_ok && !in_level;
  assign out_free   = !out_valid || m_tready;
  assign advance    = in_valid && (!has_result || out_free);
  assign s_tready   = !in_valid || advance;
  assign code_char  = lookup_code(element_count, element_bits);

  always_comb begin
    key_down_next         = key_down;
    last_edge_time_next   = last_edge_time;
    press_start_time_next = press_start_time;
    element_bits_next     = element_bits;
    element_count_next    = element_count;
    letters_in_word_next  = letters_in_word;
    kind_next             = EV_DOT;
    char_next             = '0;
    len_next              = letters_in_word;
    is_dash               = 1'b0;
    if (edge_ok) begin
      last_edge_time_next = in_time;
      key_down_next       = in_level;
      if (in_level) begin
        press_start_time_next = in_time;
      end else if (dur <= dash_limit || dur <= dot_limit) begin
        is_dash   = !(dur <= dot_limit);
        kind_next = is_dash ? EV_DASH : EV_DOT;
        if (element_count < MAX_ELEMENTS) begin
          element_bits_next  = element_bits | (BITS_W'(is_dash) << element_count);
          element_count_next = element_count + 3'd1;
        end else begin
          element_count_next = TOO_LONG;
        end
      end else if (dur <= letter_limit) begin
        if (code_char != '0 && letters_in_word < WORD_FULL) begin
          letters_in_word_next = letters_in_word + 6'd1;
          kind_next            = EV_LETTER;
          char_next            = code_char;
        end else begin
          kind_next = EV_INVALID;
        end
        element_bits_next  = '0;
        element_count_next = '0;
        len_next           = letters_in_word_next;
      end else begin
        kind_next            = EV_WORD_END;
        letters_in_word_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid         <= 1'b0;
      key_down         <= 1'b0;
      last_edge_time   <= '0;
      press_start_time <= '0;
      element_bits     <= '0;
      element_count    <= '0;
      letters_in_word  <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        key_down         <= key_down_next;
        last_edge_time   <= last_edge_time_next;
        press_start_time <= press_start_time_next;
        element_bits     <= element_bits_next;
        element_count    <= element_count_next;
        letters_in_word  <= letters_in_word_next;
      end
      if (advance && has_result) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_level <= s_tdata[0];
      in_time  <= s_tdata[16:1];
    end
    if (advance && has_result) begin
      out_kind <= kind_next;
      out_char <= char_next;
      out_time <= dur;
      out_len  <= len_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_len, out_time, out_char};
  assign m_tuser  = {5'b00000, out_kind};

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    element_count <= TOO_LONG)
    else $error("element count out of range");

  a_word_bound: assert property (@(posedge clk) disable iff (rst)
    letters_in_word <= WORD_FULL)
    else $error("word store overrun");

  a_letter_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && has_result && (kind_next == EV_LETTER || kind_next == EV_INVALID))
    |=> (element_count == '0 && element_bits == '0))
    else $error("elements not cleared at letter end");

  a_char_only_letter: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind != EV_LETTER) |-> (out_char == '0))
    else $error("char code on non-letter event");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && has_result && out_valid && !m_tready))
    else $error("input stalled without a pending result");

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// testbench for the morse key press decoder: key sample streams, scoreboard and result checks
import mkpd_pkg::*;

class key_event_board;
  typedef struct {
    event_kind_t       kind;
    logic [CHAR_W-1:0] ch;
    logic [TIME_W-1:0] dur;
    logic [WLEN_W-1:0] wlen;
  } key_event_t;

  int unsigned        store_size;
  logic [TIME_W-1:0]  gap;
  logic [TIME_W-1:0]  dot_max;
  logic [TIME_W-1:0]  dash_max;
  logic [TIME_W-1:0]  letter_max;
  logic               key_is_down;
  logic [TIME_W-1:0]  last_edge;
  logic [TIME_W-1:0]  press_start;
  logic [BITS_W-1:0]  elem_bits;
  logic [COUNT_W-1:0] elem_count;
  logic [WLEN_W-1:0]  letters;
  string              morse[36];
  key_event_t         pending_events[$];
  int                 mismatches;

  function new(int unsigned size);
    store_size  = size;
    gap         = GAP_RESET;
    dot_max     = DOT_RESET;
    dash_max    = DASH_RESET;
    letter_max  = LETTER_RESET;
    key_is_down = 1'b0;
    last_edge   = '0;
    press_start = '0;
    elem_bits   = '0;
    elem_count  = '0;
    letters     = '0;
    mismatches  = 0;
    morse = '{"*-", "-***", "-*-*", "-**", "*", "**-*", "--*", "****", "**",
              "*---", "-*-", "*-**", "--", "-*", "---", "*--*", "--*-", "*-*",
              "***", "-", "**-", "***-", "*--", "-**-", "-*--", "--**",
              "-----", "*----", "**---", "***--", "****-", "*****", "-****",
              "--***", "---**", "----*"};
  endfunction

  function void write_reg(cfg_reg_t idx, logic [TIME_W-1:0] v);
    case (idx)
      REG_DEBOUNCE_GAP: gap        = v;
      REG_DOT_LIMIT:    dot_max    = v;
      REG_DASH_LIMIT:   dash_max   = v;
      REG_LETTER_LIMIT: letter_max = v;
      default: ;
    endcase
  endfunction

  function logic [CHAR_W-1:0] decode_letter();
    logic [BITS_W-1:0] pat;
    int                len;
    for (int e = 0; e < 36; e++) begin
      len = morse[e].len();
      pat = '0;
      for (int i = 0; i < len; i++) begin
        if (morse[e][i] == "-") pat[i] = 1'b1;
      end
      if (len == int'(elem_count) && pat == elem_bits) begin
        return (e < 26) ? CHAR_W'("A" + e) : CHAR_W'("0" + e - 26);
      end
    end
    return '0;
  endfunction

  function void add_element(logic is_dash);
    if (elem_count < MAX_ELEMENTS) begin
      if (is_dash) elem_bits[elem_count] = 1'b1;
      elem_count++;
    end else begin
      elem_count = TOO_LONG;
    end
  endfunction

  function void note_sample(logic level, logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] since;
    logic [TIME_W-1:0] dur;
    logic [CHAR_W-1:0] c;
    key_event_t        ev;
    since = t - last_edge;
    if (since <= gap || level == key_is_down) return;
    last_edge = t;
    if (level) begin
      press_start = t;
      key_is_down = 1'b1;
      return;
    end
    key_is_down = 1'b0;
    dur    = t - press_start;
    ev.ch  = '0;
    ev.dur = dur;
    if (dur <= dot_max) begin
      add_element(1'b0);
      ev.kind = EV_DOT;
      ev.wlen = letters;
    end else if (dur <= dash_max) begin
      add_element(1'b1);
      ev.kind = EV_DASH;
      ev.wlen = letters;
    end else if (dur <= letter_max) begin
      c = '0;
      if (elem_count >= 1 && elem_count <= MAX_ELEMENTS) c = decode_letter();
      if (c != 0 && letters < store_size - 1) begin
        letters++;
        ev.kind = EV_LETTER;
        ev.ch   = c;
      end else begin
        ev.kind = EV_INVALID;
      end
      elem_bits  = '0;
      elem_count = '0;
      ev.wlen    = letters;
    end else begin
      ev.kind = EV_WORD_END;
      ev.wlen = letters;
      letters = '0;
    end
    pending_events.push_back(ev);
  endfunction

  function void check_result(logic [2:0] kind, logic [CHAR_W-1:0] ch,
                             logic [TIME_W-1:0] dur, logic [WLEN_W-1:0] wlen);
    key_event_t want;
    if (pending_events.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: kind %0d char %0d press %0d length %0d",
                 kind, ch, dur, wlen);
      return;
    end
    want = pending_events.pop_front();
    if (kind !== want.kind || ch !== want.ch || dur !== want.dur || wlen !== want.wlen) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected kind %0d char %0d press %0d length %0d, %s%0d %s%0d %s%0d %s%0d",
                 want.kind, want.ch, want.dur, want.wlen,
                 "got kind ", kind, "char ", ch, "press ", dur, "length ", wlen);
    end
  endfunction
endclass

module testbench;
  localparam int unsigned STORE_SIZE = 64;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic [7:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  key_event_board    board;
  bit                idle_on;
  bit                stall_on;
  logic [TIME_W-1:0] now;
  int unsigned       samples_sent;

  morse_key_press_decoder #(.WORD_STORE_SIZE(STORE_SIZE)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_result(m_tuser[2:0], m_tdata[6:0], m_tdata[22:7], m_tdata[28:23]);
  end

  initial begin
    m_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (stall_on && $urandom_range(9, 0) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(18, 1)) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic send_sample(input logic level, input logic [TIME_W-1:0] t);
    if (idle_on && $urandom_range(4, 0) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(18, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, t, level};
    do @(posedge clk); while (!s_tready);
    board.note_sample(level, t);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [TIME_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, v);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending_events.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_limits(input logic [TIME_W-1:0] g, input logic [TIME_W-1:0] d,
                            input logic [TIME_W-1:0] da, input logic [TIME_W-1:0] l);
    drain();
    write_reg(REG_DEBOUNCE_GAP, g);
    write_reg(REG_DOT_LIMIT, d);
    write_reg(REG_DASH_LIMIT, da);
    write_reg(REG_LETTER_LIMIT, l);
    cfg_valid <= 1'b0;
  endtask

  // duration that lands in the wanted class under the current limits, random if none can
  function automatic logic [TIME_W-1:0] pick_press(event_kind_t cls);
    int dot_v;
    int dash_v;
    int letter_v;
    int upper;
    int lo;
    int hi;
    dot_v    = int'(board.dot_max);
    dash_v   = int'(board.dash_max);
    letter_v = int'(board.letter_max);
    upper    = (dot_v > dash_v) ? dot_v : dash_v;
    case (cls)
      EV_DOT: begin
        lo = 0;
        hi = dot_v;
      end
      EV_DASH: begin
        lo = dot_v + 1;
        hi = dash_v;
      end
      EV_LETTER: begin
        lo = upper + 1;
        hi = letter_v;
      end
      default: begin
        lo = ((upper > letter_v) ? upper : letter_v) + 1;
        hi = 65535;
      end
    endcase
    if (lo < int'(board.gap) + 1) lo = int'(board.gap) + 1;
    if (lo > hi) return TIME_W'($urandom_range(65535, 0));
    case ($urandom_range(3, 0))
      0:       return TIME_W'(lo);
      1:       return TIME_W'(hi);
      default: return TIME_W'($urandom_range(hi, lo));
    endcase
  endfunction

  task automatic key_press(input logic [TIME_W-1:0] dur);
    logic [TIME_W-1:0] start;
    now   = now + board.gap + TIME_W'(1) + TIME_W'($urandom_range(300, 0));
    start = now;
    send_sample(1'b1, start);
    // contact bounce inside the debounce window
    if ($urandom_range(5, 0) == 0)
      send_sample(1'($urandom_range(1, 0)), start + TIME_W'($urandom_range(board.gap, 0)));
    now = start + dur;
    send_sample(1'b0, now);
    samples_sent += 2;
  endtask

  task automatic key_noise();
    now = TIME_W'($urandom_range(65535, 0));
    send_sample(1'($urandom_range(1, 0)), now);
    samples_sent++;
  endtask

  task automatic key_letter(input int n);
    for (int i = 0; i < n; i++)
      key_press(pick_press(($urandom_range(1, 0) == 0) ? EV_DOT : EV_DASH));
    key_press(pick_press(EV_LETTER));
  endtask

  task automatic key_word();
    int r;
    repeat ($urandom_range(6, 1)) begin
      r = $urandom_range(9, 0);
      if (r < 8) key_letter($urandom_range(5, 1));
      else if (r == 8) key_letter(0);
      else key_letter($urandom_range(7, 6));
    end
    key_press(pick_press(EV_WORD_END));
  endtask

  task automatic run_phase(input int unsigned count);
    int unsigned target;
    target = samples_sent + count;
    while (samples_sent < target) begin
      case ($urandom_range(9, 0))
        0:       key_noise();
        1:       key_press(TIME_W'($urandom_range(65535, 0)));
        default: key_word();
      endcase
    end
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_DEBOUNCE_GAP;
    cfg_data     = '0;
    idle_on      = 1'b1;
    stall_on     = 1'b1;
    samples_sent = 0;
    now          = '0;
    board        = new(STORE_SIZE);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_sample(1'b1, 16'd0);
    send_sample(1'b0, 16'd60);
    send_sample(1'b1, 16'd100);
    send_sample(1'b0, 16'd130);
    send_sample(1'b0, 16'd2100);
    send_sample(1'b1, 16'd2200);
    send_sample(1'b0, 16'd4201);
    send_sample(1'b1, 16'd4300);
    send_sample(1'b0, 16'd8301);
    send_sample(1'b1, 16'd8400);
    send_sample(1'b0, 16'd18400);
    for (int i = 0; i < 5; i++) begin
      send_sample(1'b1, TIME_W'(18500 + i * 4100));
      send_sample(1'b0, TIME_W'(22500 + i * 4100));
    end
    send_sample(1'b1, 16'd39000);
    send_sample(1'b0, 16'd44000);
    send_sample(1'b1, 16'd44100);
    send_sample(1'b0, 16'd54101);
    now = 16'd54101;

    run_phase(80);
    set_limits(16'd0, 16'd100, 16'd300, 16'd1000);
    repeat (STORE_SIZE + 3) key_letter(1);
    key_press(pick_press(EV_WORD_END));
    run_phase(70);
    set_limits(16'hFFFF, 16'd500, 16'd1000, 16'd2000);
    repeat (20) key_noise();
    key_word();
    set_limits(16'd10, 16'd0, 16'hFFFF, 16'hFFFF);
    run_phase(50);
    set_limits(16'd5, 16'd3000, 16'd1000, 16'd500);
    run_phase(50);
    set_limits(16'd30, 16'hFFFF, 16'd0, 16'd0);
    run_phase(40);
    set_limits(16'd20, 16'd500, 16'd1500, 16'd4000);
    idle_on  = 1'b0;
    stall_on = 1'b0;
    run_phase(60);
    drain();

    if (board.mismatches == 0 && board.pending_events.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
